// File: hdl/mcss_pkg.sv
// ----------------------------------------------------------------------------
// mcss_pkg
// Shared types and constants for the matrix cumulative sum scan.
// ----------------------------------------------------------------------------
package mcss_pkg;

  localparam int ELEM_WIDTH = 32;
  localparam int POS_WIDTH  = 10;
  localparam int LEN_WIDTH  = 11;
  localparam int MODE_WIDTH = 2;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_FLAT = 2'd0,
    MODE_ROW  = 2'd1,
    MODE_COL  = 2'd2
  } scan_mode_t;

  localparam logic REG_SCAN_MODE  = 1'b0;
  localparam logic REG_ROW_LENGTH = 1'b1;

  // per-word control decided by the front end
  typedef struct packed {
    logic column;
    logic fresh;
    logic last;
  } item_ctrl_t;

endpackage

// File: hdl/mcss_front.sv
// ----------------------------------------------------------------------------
// mcss_front
// Accepts input words, tracks row and column position and tags each word.
// ----------------------------------------------------------------------------
module mcss_front #(
  parameter int MAX_COLUMNS = 1024,
  parameter int DATA_WIDTH  = 32,
  parameter int ADDR_WIDTH  = 10
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [mcss_pkg::ELEM_WIDTH-1:0]         s_axis_tdata,
  input  logic                                    s_axis_tlast,
  input  logic [mcss_pkg::MODE_WIDTH-1:0]         scan_mode,
  input  logic [mcss_pkg::LEN_WIDTH-1:0]          row_length,
  input  logic                                    q_ready,
  output logic                                    q_push,
  output mcss_pkg::item_ctrl_t                    q_ctrl,
  output logic [ADDR_WIDTH-1:0]                   q_col,
  output logic [DATA_WIDTH-1:0]                   q_value
);
  import mcss_pkg::*;

  localparam int XW      = (DATA_WIDTH > ELEM_WIDTH) ? DATA_WIDTH : ELEM_WIDTH;
  localparam int LEN_CAP = (MAX_COLUMNS > 2047) ? 2047 : MAX_COLUMNS;
  localparam logic [LEN_WIDTH-1:0] LenCap = LEN_WIDTH'(LEN_CAP);
  localparam logic [LEN_WIDTH-1:0] LenOne = LEN_WIDTH'(1);

  logic [POS_WIDTH-1:0] position;
  logic                 in_first_row;

  logic [LEN_WIDTH-1:0] len;
  logic [POS_WIDTH-1:0] pos_eff;
  logic [LEN_WIDTH-1:0] pos_inc;
  logic                 wrap;
  logic [XW-1:0]        x_ext;

  assign len = (row_length == '0) ? LenOne :
               ((row_length > LenCap) ? LenCap : row_length);
  assign pos_eff = ({1'b0, position} >= len) ? '0 : position;
  assign pos_inc = {1'b0, pos_eff} + LenOne;
  assign wrap    = (pos_inc >= len);
  assign x_ext   = XW'($signed(s_axis_tdata));

  assign s_axis_tready = q_ready;
  assign q_push        = s_axis_tvalid && q_ready;
  assign q_col         = ADDR_WIDTH'(pos_eff);
  assign q_value       = x_ext[DATA_WIDTH-1:0];

  always_comb begin
    q_ctrl.last   = s_axis_tlast;
    q_ctrl.column = (scan_mode == MODE_COL);
    unique case (scan_mode)
      MODE_ROW: q_ctrl.fresh = (pos_eff == '0);
      MODE_COL: q_ctrl.fresh = in_first_row;
      default:  q_ctrl.fresh = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      in_first_row <= 1'b1;
    end else if (q_push) begin
      if (s_axis_tlast) begin
        position     <= '0;
        in_first_row <= 1'b1;
      end else if (wrap) begin
        position     <= '0;
        in_first_row <= 1'b0;
      end else begin
        position     <= pos_inc[POS_WIDTH-1:0];
      end
    end
  end

endmodule

// File: hdl/mcss_queue.sv
// ----------------------------------------------------------------------------
// mcss_queue
// Small first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mcss_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             ready,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid
);
  import mcss_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(DEPTH);
  localparam logic [PW-1:0] Last = PW'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign ready = (count != Full);
  assign valid = (count != '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Last) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Last) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: hdl/mcss_back.sv
// ----------------------------------------------------------------------------
// mcss_back
// Reads the column store, adds each word to its running sum, drives output.
// ----------------------------------------------------------------------------
module mcss_back #(
  parameter int MAX_COLUMNS = 1024,
  parameter int DATA_WIDTH  = 32,
  parameter int ADDR_WIDTH  = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  mcss_pkg::item_ctrl_t            q_ctrl,
  input  logic [ADDR_WIDTH-1:0]           q_col,
  input  logic [DATA_WIDTH-1:0]           q_value,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mcss_pkg::ELEM_WIDTH-1:0] m_axis_tdata,
  output logic                            m_axis_tlast
);
  import mcss_pkg::*;

  localparam int XW = (DATA_WIDTH > ELEM_WIDTH) ? DATA_WIDTH : ELEM_WIDTH;

  logic [DATA_WIDTH-1:0] col_mem [MAX_COLUMNS];

  logic                  r_valid;
  item_ctrl_t            r_ctrl;
  logic [ADDR_WIDTH-1:0] r_col;
  logic [DATA_WIDTH-1:0] r_value;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  byp_hit;
  logic [DATA_WIDTH-1:0] byp_data;
  logic [DATA_WIDTH-1:0] flat_sum;

  logic                  advance;
  logic                  mem_we;
  logic [DATA_WIDTH-1:0] base;
  logic [DATA_WIDTH-1:0] total;
  logic [XW-1:0]         total_ext;

  assign advance   = r_valid && (!m_axis_tvalid || m_axis_tready);
  assign q_pop     = q_valid && (!r_valid || advance);
  assign mem_we    = advance && r_ctrl.column;
  assign base      = r_ctrl.column ? (byp_hit ? byp_data : rd_data) : flat_sum;
  assign total     = r_ctrl.fresh ? r_value : base + r_value;
  assign total_ext = XW'($signed(total));

  // column store, read-before-write, no reset
  always_ff @(posedge clk) begin
    if (mem_we) begin
      col_mem[r_col] <= total;
    end
    if (q_pop) begin
      rd_data  <= col_mem[q_col];
      byp_hit  <= mem_we && (r_col == q_col);
      byp_data <= total;
      r_ctrl   <= q_ctrl;
      r_col    <= q_col;
      r_value  <= q_value;
    end
    if (advance) begin
      m_axis_tdata <= total_ext[ELEM_WIDTH-1:0];
      m_axis_tlast <= r_ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid       <= 1'b0;
      m_axis_tvalid <= 1'b0;
      flat_sum      <= '0;
    end else begin
      if (q_pop) begin
        r_valid <= 1'b1;
      end else if (advance) begin
        r_valid <= 1'b0;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
        if (r_ctrl.last) begin
          flat_sum <= '0;
        end else if (!r_ctrl.column) begin
          flat_sum <= total;
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/matrix_cumulative_sum_scan.sv
// ----------------------------------------------------------------------------
// matrix_cumulative_sum_scan
// Inclusive cumulative sum over a streamed vector or row-major matrix.
//
// Input words arrive on s_axis in row-major order, tlast on the final element
// of the array. Each input word gives exactly one output word on m_axis with
// the inclusive running sum; tlast is copied through. Mode flat keeps one sum
// over the array, mode row restarts it at each row start, mode column keeps a
// sum per column in an on-chip column store of MAX_COLUMNS entries.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must write it only while the block is idle (unchecked): index 0 scan mode,
// index 1 row length. Throughput: one word per cycle unless m_axis stalls;
// the column store has one read and one write port, and a word that reads the
// column just written takes the bypassed sum. A stalled receiver fills the
// output register, the sum stage and a four-word queue, then tready drops.
// Reset returns the mode to flat, the row length to 1024 and the position to
// the first row; the column store is not cleared, the first row of every
// array writes it before it is read.
// ----------------------------------------------------------------------------
module matrix_cumulative_sum_scan #(
  parameter int MAX_COLUMNS = 1024,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mcss_pkg::ELEM_WIDTH-1:0] s_axis_tdata,  // element_value
  input  logic                            s_axis_tlast,  // array_end
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mcss_pkg::ELEM_WIDTH-1:0] m_axis_tdata,  // running_total
  output logic                            m_axis_tlast,  // final_flag
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [mcss_pkg::LEN_WIDTH-1:0]  cfg_data
);
  import mcss_pkg::*;

  localparam int ADDR_WIDTH = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int QW         = $bits(item_ctrl_t) + ADDR_WIDTH + DATA_WIDTH;
  localparam int QDEPTH     = 4;

  logic [MODE_WIDTH-1:0] scan_mode;
  logic [LEN_WIDTH-1:0]  row_length;

  logic                  q_push;
  logic                  q_ready;
  logic                  q_pop;
  logic                  q_valid;
  item_ctrl_t            f_ctrl;
  logic [ADDR_WIDTH-1:0] f_col;
  logic [DATA_WIDTH-1:0] f_value;
  logic [QW-1:0]         q_wdata;
  logic [QW-1:0]         q_rdata;
  item_ctrl_t            b_ctrl;
  logic [ADDR_WIDTH-1:0] b_col;
  logic [DATA_WIDTH-1:0] b_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode  <= MODE_FLAT;
      row_length <= LEN_WIDTH'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCAN_MODE:  scan_mode  <= cfg_data[MODE_WIDTH-1:0];
        REG_ROW_LENGTH: row_length <= cfg_data;
        default: ;
      endcase
    end
  end

  mcss_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .scan_mode    (scan_mode),
    .row_length   (row_length),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_ctrl       (f_ctrl),
    .q_col        (f_col),
    .q_value      (f_value)
  );

  assign q_wdata = {f_value, f_col, f_ctrl};
  assign {b_value, b_col, b_ctrl} = q_rdata;

  mcss_queue #(
    .WIDTH(QW),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .ready(q_ready),
    .pop  (q_pop),
    .rdata(q_rdata),
    .valid(q_valid)
  );

  mcss_back #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_ctrl       (b_ctrl),
    .q_col        (b_col),
    .q_value      (b_value),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // pipeline is empty and open right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("pipeline not empty after reset");

  // an empty queue never refuses a word
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> s_axis_tready)
    else $error("input stalled with empty queue");

  // a pop only happens from a queue holding a word
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

// File: test/matrix_cumulative_sum_scan_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_cumulative_sum_scan_tb
// Self-checking bench for the streaming cumulative sum scan.
//
// Words are driven on s_axis and every accepted word is run through a local
// model of the flat, row and column scans. The model's sums are queued, and
// each word taken from m_axis is compared with the oldest one. Directed arrays
// cover the sum extremes, every mode and the odd row lengths. A full-width
// row, a long receiver hold-off and a gap-free stream follow. Random arrays
// then mix modes, row lengths, whole-row and cut-short arrays, and random
// stalls on both sides. Configuration changes only between arrays, with the
// block drained.
// ----------------------------------------------------------------------------
module matrix_cumulative_sum_scan_tb;
  import mcss_pkg::*;

  localparam int ROW_CAP = 1024;
  localparam logic [MODE_WIDTH-1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic [ELEM_WIDTH-1:0] sum;
    logic                  last;
  } sum_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ELEM_WIDTH-1:0] s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [ELEM_WIDTH-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [LEN_WIDTH-1:0]  cfg_data = '0;

  // scan state as the block should hold it
  logic [MODE_WIDTH-1:0] set_mode = MODE_FLAT;
  logic [LEN_WIDTH-1:0]  set_len = 11'd1024;
  logic [ELEM_WIDTH-1:0] run_sum = '0;
  logic [POS_WIDTH-1:0]  cur_pos = '0;
  logic                  first_row = 1'b1;
  logic [ELEM_WIDTH-1:0] col_store [ROW_CAP];

  sum_word_t pending_sums[$];
  sum_word_t head_sum;

  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;
  int sink_hold = 0;
  int fail_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int arrays_closed = 0;

  matrix_cumulative_sum_scan u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // element_value
    .s_axis_tlast  (s_axis_tlast),   // array_end
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // running_total
    .m_axis_tlast  (m_axis_tlast),   // final_flag
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int row_span();
    if (set_len == 0) return 1;
    if (set_len > ROW_CAP) return ROW_CAP;
    return int'(set_len);
  endfunction

  function automatic void predict_sum(input logic [ELEM_WIDTH-1:0] x, input logic last);
    int span;
    int pos;
    logic [ELEM_WIDTH-1:0] total;
    span = row_span();
    pos = int'(cur_pos);
    if (pos >= span) pos = 0;
    case (set_mode)
      MODE_ROW: begin
        total = (pos == 0) ? x : run_sum + x;
        run_sum = total;
      end
      MODE_COL: begin
        total = first_row ? x : col_store[pos] + x;
        col_store[pos] = total;
      end
      default: begin
        total = run_sum + x;
        run_sum = total;
      end
    endcase
    pos++;
    if (pos >= span) begin
      pos = 0;
      first_row = 1'b0;
    end
    cur_pos = POS_WIDTH'(pos);
    if (last) begin
      cur_pos = '0;
      run_sum = '0;
      first_row = 1'b1;
      arrays_closed++;
    end
    pending_sums.push_back('{total, last});
    words_sent++;
  endfunction

  function automatic logic [ELEM_WIDTH-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [ELEM_WIDTH-1:0] value, input logic last);
    @(negedge clk);
    while (!src_steady && $urandom_range(99) < 27) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = value;
    s_axis_tlast = last;
    do @(posedge clk); while (!s_axis_tready);
    predict_sum(value, last);
  endtask

  task automatic send_array(input int count);
    for (int i = 0; i < count; i++) send_word(pick_value(), i == count - 1);
  endtask

  task automatic wait_sums_done();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [LEN_WIDTH-1:0] value);
    wait_sums_done();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_SCAN_MODE) set_mode = value[MODE_WIDTH-1:0];
    else set_len = value;
  endtask

  // receiver side
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = sink_steady || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_sums.size() == 0) begin
        $error("running_total: no word expected, got %h", m_axis_tdata);
        fail_count++;
      end else begin
        head_sum = pending_sums.pop_front();
        words_checked++;
        if (m_axis_tdata !== head_sum.sum) begin
          $error("running_total: expected %h, got %h", head_sum.sum, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== head_sum.last) begin
          $error("final_flag: expected %b, got %b", head_sum.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // reset values: flat mode, rows of 1024, sums wrap
  task automatic test_reset_defaults();
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b1);
  endtask

  task automatic test_row_restart();
    write_reg(REG_SCAN_MODE, 11'(MODE_ROW));
    write_reg(REG_ROW_LENGTH, 11'd3);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h0000_0005, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b1);
  endtask

  task automatic test_column_sums();
    write_reg(REG_SCAN_MODE, 11'(MODE_COL));
    write_reg(REG_ROW_LENGTH, 11'd2);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(32'h8000_0000, 1'b1);
  endtask

  // spare mode code runs flat, zero length acts as one column
  task automatic test_spare_mode_short_rows();
    write_reg(REG_SCAN_MODE, 11'(MODE_SPARE));
    write_reg(REG_ROW_LENGTH, 11'd0);
    send_word(32'h4000_0000, 1'b0);
    send_word(32'h4000_0000, 1'b0);
    send_word(32'hC000_0000, 1'b1);
    write_reg(REG_SCAN_MODE, 11'(MODE_COL));
    send_word(32'h0000_0003, 1'b0);
    send_word(32'hFFFF_FFFE, 1'b1);
  endtask

  task automatic test_single_word();
    write_reg(REG_SCAN_MODE, 11'(MODE_ROW));
    write_reg(REG_ROW_LENGTH, 11'd1);
    send_word(32'hDEAD_BEEF, 1'b1);
  endtask

  // oversize length saturates to the full column store
  task automatic test_long_rows();
    write_reg(REG_SCAN_MODE, 11'(MODE_COL));
    write_reg(REG_ROW_LENGTH, 11'd2047);
    send_array(ROW_CAP + 2);
    write_reg(REG_SCAN_MODE, 11'(MODE_ROW));
    write_reg(REG_ROW_LENGTH, 11'd1024);
    send_array(8);
  endtask

  task automatic test_backpressure();
    write_reg(REG_SCAN_MODE, 11'(MODE_COL));
    write_reg(REG_ROW_LENGTH, 11'd5);
    @(posedge clk);
    sink_hold = 80;
    src_steady = 1'b1;
    send_array(42);
    src_steady = 1'b0;
    wait_sums_done();
  endtask

  task automatic test_steady_stream();
    write_reg(REG_SCAN_MODE, 11'(MODE_ROW));
    write_reg(REG_ROW_LENGTH, 11'd7);
    src_steady = 1'b1;
    sink_steady = 1'b1;
    send_array(21);
    send_array(14);
    write_reg(REG_SCAN_MODE, 11'(MODE_FLAT));
    send_array(12);
    src_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  task automatic test_random_arrays();
    int span;
    int count;
    int stop_at;
    stop_at = words_sent + 80;
    while (words_sent < stop_at) begin
      if ($urandom_range(1) == 0) begin
        write_reg(REG_SCAN_MODE, 11'($urandom_range(3)));
        case ($urandom_range(19))
          0, 1: write_reg(REG_ROW_LENGTH, 11'd0);
          2: write_reg(REG_ROW_LENGTH, 11'($urandom_range(2047, 1025)));
          3, 4, 5: write_reg(REG_ROW_LENGTH, 11'($urandom_range(64, 9)));
          default: write_reg(REG_ROW_LENGTH, 11'($urandom_range(8, 1)));
        endcase
      end
      span = row_span();
      count = span * $urandom_range(4, 1);
      if (count > 48 || $urandom_range(3) == 0) count = $urandom_range(48, 1);
      send_array(count);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_row_restart();
    test_column_sums();
    test_spare_mode_short_rows();
    test_single_word();
    test_long_rows();
    test_backpressure();
    test_steady_stream();
    test_random_arrays();
    wait_sums_done();
    repeat (20) @(posedge clk);
    if (pending_sums.size() != 0) begin
      $error("running_total: %0d words never arrived", pending_sums.size());
      fail_count++;
    end
    $display("summary: %0d words in %0d arrays checked, %0d mismatches", words_checked,
             arrays_closed, fail_count);
    $display("summary: flat, row, column and spare modes, row lengths 0 to 2047, stalls");
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: matrix_cumulative_sum_scan.f
hdl/mcss_pkg.sv
hdl/mcss_front.sv
hdl/mcss_queue.sv
hdl/mcss_back.sv
hdl/matrix_cumulative_sum_scan.sv
test/matrix_cumulative_sum_scan_tb.sv
